>>> hdl/euler_zxy_rotation_matrix_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Z-X-Y rotation matrix block
// ----------------------------------------------------------------------------
`ifndef EULER_ZXY_ROTATION_MATRIX_ASSERT_SVH
`define EULER_ZXY_ROTATION_MATRIX_ASSERT_SVH

// Implication checked on every clock edge out of reset.
`define EZRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that holds on every clock edge out of reset.
`define EZRM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

>>> hdl/ezrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezrm_pkg
// Constants, types and helpers for the Z-X-Y rotation matrix pipeline.
// ----------------------------------------------------------------------------
package ezrm_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF  = 16;

  // Register stages: 21 for sine/cosine, 7 for the matrix.
  localparam int TRIG_LAST  = 21;
  localparam int PIPE_DEPTH = 28;

  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [29:0] Q30_EIGHTH = 30'h2000_0000;
  localparam logic [31:0] TWO_PI_Q29 = 32'hC90F_DAA2;

  localparam int SIN_STEPS = 5;
  localparam int COS_STEPS = 6;
  localparam int unsigned SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] tc;
    logic [30:0] ts;
    logic [30:0] pc;
    logic [30:0] ps;
    logic [1:0]  quad;
    logic        swap;
  } trig_t;

  // Drop 30 fraction bits, round to nearest, ties away from zero.
  function automatic logic signed [31:0] round_q30(input logic signed [63:0] p);
    logic [63:0] m;
    m = p[63] ? 64'(-p) : 64'(p);
    m = (m + 64'(Q30_EIGHTH)) >> 30;
    round_q30 = p[63] ? -$signed(m[31:0]) : $signed(m[31:0]);
  endfunction

endpackage

>>> hdl/euler_zxy_rotation_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_zxy_rotation_matrix
// Binary angles about X, Y and Z in, Z-X-Y rotation matrix entries out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries angle_x, angle_y, angle_z, binary
//   angles with 2^ANGLE_WIDTH units per turn. Output channel out_valid/
//   out_ready carries r00..r22, signed with COEF_WIDTH-2 fraction bits,
//   rounded and saturated to +-1.0. Every transaction in gives one out.
//   There are 21 stages of sine/cosine (angle fold, radian
//   scale, square, then six polynomial steps of three stages each: product,
//   reciprocal multiply, correction) and 7 stages of quadrant mapping, matrix
//   products, rounding, sums and output rounding. One transaction per cycle is
//   taken as long as the output side keeps up.
//   Each stage holds its own valid bit and advances when the next stage
//   frees up, so bubbles close up while the receiver stalls; the finished
//   result is held until taken. in_ready drops only when every stage holds
//   an item. Reset (rst, synchronous) clears all valid bits; no state is
//   kept between transactions.
// ----------------------------------------------------------------------------
module euler_zxy_rotation_matrix #(
  parameter int ANGLE_WIDTH = ezrm_pkg::ANGLE_WIDTH_DEF,
  parameter int COEF_WIDTH  = ezrm_pkg::COEF_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ANGLE_WIDTH-1:0]        angle_x,
  input  logic [ANGLE_WIDTH-1:0]        angle_y,
  input  logic [ANGLE_WIDTH-1:0]        angle_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COEF_WIDTH-1:0]  r00,
  output logic signed [COEF_WIDTH-1:0]  r01,
  output logic signed [COEF_WIDTH-1:0]  r02,
  output logic signed [COEF_WIDTH-1:0]  r10,
  output logic signed [COEF_WIDTH-1:0]  r11,
  output logic signed [COEF_WIDTH-1:0]  r12,
  output logic signed [COEF_WIDTH-1:0]  r20,
  output logic signed [COEF_WIDTH-1:0]  r21,
  output logic signed [COEF_WIDTH-1:0]  r22
);

  localparam int N     = ezrm_pkg::PIPE_DEPTH;
  localparam int TL    = ezrm_pkg::TRIG_LAST;
  localparam int ASH   = 32 - ANGLE_WIDTH;
  localparam int SH    = 32 - COEF_WIDTH;
  localparam logic [32:0] HALF  = (SH == 0) ? 33'd0 : (33'd1 << (SH - 1));
  localparam logic [32:0] LIM_U = 33'd1 << (COEF_WIDTH - 2);
  localparam int COEF_LIM = 2 ** (COEF_WIDTH - 2);

  function automatic logic [COEF_WIDTH-1:0] to_coef(input logic signed [32:0] e);
    logic [32:0] m;
    m = e[32] ? 33'(-e) : 33'(e);
    m = (m + HALF) >> SH;
    if (m > LIM_U) m = LIM_U;
    to_coef = e[32] ? COEF_WIDTH'(-m) : COEF_WIDTH'(m);
  endfunction

  // --------------------------------------------------------------------------
  // Stage valid bits and advance enables
  // --------------------------------------------------------------------------
  logic [N:1]   vld;
  logic [N+1:1] en;

  assign en[N+1] = out_ready;
  for (genvar i = 1; i <= N; i++) begin : g_en
    assign en[i] = ~vld[i] | en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int i = 2; i <= N; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[N];

  // --------------------------------------------------------------------------
  // Sine and cosine, one lane per angle
  // --------------------------------------------------------------------------
  logic [ANGLE_WIDTH-1:0] ang [3];
  assign ang[0] = angle_x;
  assign ang[1] = angle_y;
  assign ang[2] = angle_z;

  ezrm_pkg::trig_t tr [3][1:TL];

  for (genvar a = 0; a < 3; a++) begin : g_lane
    for (genvar s = 1; s <= TL; s++) begin : g_st
      ezrm_pkg::trig_t nx;

      if (s == 1) begin : g_fold
        logic [31:0] a32;
        logic [29:0] u;
        assign a32 = 32'(ang[a]) << ASH;
        assign u   = a32[29:0];
        // Fold the quadrant onto [0, pi/4]; swap sine and cosine above it.
        always_comb begin
          nx      = '0;
          nx.quad = a32[31:30];
          nx.swap = u > ezrm_pkg::Q30_EIGHTH;
          nx.x    = nx.swap ? 30'(ezrm_pkg::Q30_ONE - 31'(u)) : u;
        end
      end else if (s == 2) begin : g_rad
        logic [62:0] xm;
        always_comb begin
          nx = tr[a][s-1];
          xm = 63'(tr[a][s-1].x) * 63'(ezrm_pkg::TWO_PI_Q29) + 63'(ezrm_pkg::Q30_ONE);
          nx.x = xm[60:31];
        end
      end else if (s == 3) begin : g_sq
        logic [59:0] sq;
        always_comb begin
          nx    = tr[a][s-1];
          sq    = 60'(tr[a][s-1].x) * 60'(tr[a][s-1].x);
          nx.x2 = sq[59:30];
          nx.tc = ezrm_pkg::Q30_ONE;
          nx.ts = ezrm_pkg::Q30_ONE;
        end
      end else begin : g_step
        localparam int J = (s - 4) / 3;
        localparam int PH = (s - 4) % 3;
        localparam bit SIN_ON = (J < ezrm_pkg::SIN_STEPS);
        localparam int unsigned KC = ezrm_pkg::COS_DIV[J];
        localparam int unsigned KS = ezrm_pkg::SIN_DIV[SIN_ON ? J : 0];
        localparam logic [31:0] MC = 32'((64'd1 << 32) / KC);
        localparam logic [31:0] MS = 32'((64'd1 << 32) / KS);

        if (PH == 0) begin : g_mul
          logic [60:0] mc;
          logic [60:0] ms;
          always_comb begin
            nx    = tr[a][s-1];
            mc    = 61'(tr[a][s-1].x2) * 61'(tr[a][s-1].tc);
            nx.pc = mc[60:30];
            if (SIN_ON) begin
              ms    = 61'(tr[a][s-1].x2) * 61'(tr[a][s-1].ts);
              nx.ps = ms[60:30];
            end else begin
              // Last step: sine = x * t.
              ms    = 61'(tr[a][s-1].x) * 61'(tr[a][s-1].ts);
              nx.ts = ms[60:30];
            end
          end
        end else if (PH == 1) begin : g_rcp
          logic [62:0] qc;
          logic [62:0] qs;
          always_comb begin
            nx    = tr[a][s-1];
            qc    = 63'(tr[a][s-1].pc) * 63'(MC);
            nx.tc = qc[62:32];
            qs    = 63'(tr[a][s-1].ps) * 63'(MS);
            if (SIN_ON) nx.ts = qs[62:32];
          end
        end else begin : g_fix
          logic [30:0] rc;
          logic [30:0] rs;
          // Reciprocal estimate is low by at most one: correct, then 1 - q.
          always_comb begin
            nx    = tr[a][s-1];
            rc    = tr[a][s-1].pc - 31'(tr[a][s-1].tc * 31'(KC));
            nx.tc = ezrm_pkg::Q30_ONE - (tr[a][s-1].tc + 31'(rc >= 31'(KC)));
            rs    = tr[a][s-1].ps - 31'(tr[a][s-1].ts * 31'(KS));
            if (SIN_ON) begin
              nx.ts = ezrm_pkg::Q30_ONE - (tr[a][s-1].ts + 31'(rs >= 31'(KS)));
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en[s]) tr[a][s] <= nx;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Quadrant mapping (stage 22)
  // --------------------------------------------------------------------------
  logic signed [31:0] sv [3];
  logic signed [31:0] cv [3];

  for (genvar a = 0; a < 3; a++) begin : g_quad
    logic signed [31:0] sp;
    logic signed [31:0] cp;
    logic signed [31:0] s_nx;
    logic signed [31:0] c_nx;
    assign sp = $signed({1'b0, tr[a][TL].swap ? tr[a][TL].tc : tr[a][TL].ts});
    assign cp = $signed({1'b0, tr[a][TL].swap ? tr[a][TL].ts : tr[a][TL].tc});
    always_comb begin
      unique case (tr[a][TL].quad)
        ezrm_pkg::QUAD_0: begin s_nx = sp;  c_nx = cp;  end
        ezrm_pkg::QUAD_1: begin s_nx = cp;  c_nx = -sp; end
        ezrm_pkg::QUAD_2: begin s_nx = -sp; c_nx = -cp; end
        default:          begin s_nx = -cp; c_nx = sp;  end
      endcase
    end
    always_ff @(posedge clk) begin
      if (en[TL+1]) begin
        sv[a] <= s_nx;
        cv[a] <= c_nx;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Matrix products, sums and output rounding (stages 23..28)
  // --------------------------------------------------------------------------
  logic signed [63:0] p1 [10];
  logic signed [31:0] sx23, sz23, cz23;
  logic signed [31:0] r1 [10];
  logic signed [31:0] sx24, sz24, cz24;
  logic signed [31:0] r1c [10];
  logic signed [63:0] p2 [4];
  logic signed [31:0] sx25;
  logic signed [31:0] r1d [10];
  logic signed [31:0] r2 [4];
  logic signed [31:0] sx26;
  logic signed [32:0] e [9];
  logic [COEF_WIDTH-1:0] co [9];

  always_ff @(posedge clk) begin
    if (en[TL+2]) begin
      p1[0] <= cv[1] * cv[2];
      p1[1] <= sv[1] * sv[0];
      p1[2] <= sv[2] * cv[0];
      p1[3] <= cv[1] * sv[0];
      p1[4] <= cv[2] * cv[0];
      p1[5] <= sv[1] * cv[2];
      p1[6] <= cv[1] * sv[2];
      p1[7] <= sv[2] * sv[1];
      p1[8] <= sv[1] * cv[0];
      p1[9] <= cv[1] * cv[0];
      sx23  <= sv[0];
      sz23  <= sv[2];
      cz23  <= cv[2];
    end
    if (en[TL+3]) begin
      for (int k = 0; k < 10; k++) r1[k] <= ezrm_pkg::round_q30(p1[k]);
      sx24 <= sx23;
      sz24 <= sz23;
      cz24 <= cz23;
    end
    if (en[TL+4]) begin
      r1c   <= r1;
      p2[0] <= r1[1] * sz24;
      p2[1] <= r1[1] * cz24;
      p2[2] <= r1[3] * sz24;
      p2[3] <= r1[3] * cz24;
      sx25  <= sx24;
    end
    if (en[TL+5]) begin
      r1d <= r1c;
      for (int k = 0; k < 4; k++) r2[k] <= ezrm_pkg::round_q30(p2[k]);
      sx26 <= sx25;
    end
    if (en[TL+6]) begin
      e[0] <= 33'(r1d[0]) + 33'(r2[0]);
      e[1] <= 33'(r1d[2]);
      e[2] <= -33'(r1d[5]) + 33'(r2[2]);
      e[3] <= -33'(r1d[6]) + 33'(r2[1]);
      e[4] <= 33'(r1d[4]);
      e[5] <= 33'(r1d[7]) + 33'(r2[3]);
      e[6] <= 33'(r1d[8]);
      e[7] <= -33'(sx26);
      e[8] <= 33'(r1d[9]);
    end
    if (en[N]) begin
      for (int k = 0; k < 9; k++) co[k] <= to_coef(e[k]);
    end
  end

  assign r00 = $signed(co[0]);
  assign r01 = $signed(co[1]);
  assign r02 = $signed(co[2]);
  assign r10 = $signed(co[3]);
  assign r11 = $signed(co[4]);
  assign r12 = $signed(co[5]);
  assign r20 = $signed(co[6]);
  assign r21 = $signed(co[7]);
  assign r22 = $signed(co[8]);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `include "euler_zxy_rotation_matrix_assert.svh"

  `EZRM_ASSERT_IMP(a_ready_free_tail, (!out_valid || out_ready), in_ready, "input stalled with free tail")
  `EZRM_ASSERT_IMP(a_r00_sat, out_valid, ($signed(r00) <= COEF_LIM && $signed(r00) >= -COEF_LIM), "r00 beyond one")
  `EZRM_ASSERT_IMP(a_r12_sat, out_valid, ($signed(r12) <= COEF_LIM && $signed(r12) >= -COEF_LIM), "r12 beyond one")
  `EZRM_ASSERT_ALWAYS(a_head_valid, (!vld[1] || !en[1] || en[2]), "stage one overwritten while held")

endmodule

>>> tb/sv/euler_zxy_rotation_matrix_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_zxy_rotation_matrix_tb
// Drives angle triples through the Z-X-Y rotation matrix block with random
// gaps and output stalls, and checks all nine matrix entries per transaction
// against typed expected values or a fixed-point sine/cosine and matrix predictor.
// ----------------------------------------------------------------------------
module euler_zxy_rotation_matrix_tb;

  localparam int AW = ezrm_pkg::ANGLE_WIDTH_DEF;
  localparam int CW = ezrm_pkg::COEF_WIDTH_DEF;
  localparam int FB = CW - 2;
  localparam int N_RANDOM = 1450;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2 * ezrm_pkg::PIPE_DEPTH;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam logic signed [CW-1:0] P1 = 16384;
  localparam logic signed [CW-1:0] M1 = -16384;

  typedef logic [8:0][CW-1:0] matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [AW-1:0] angle_x = '0;
  logic [AW-1:0] angle_y = '0;
  logic [AW-1:0] angle_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  matrix_t pending_matrices[$];
  int errors = 0;
  int idle_cycles = 0;

  euler_zxy_rotation_matrix dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Round off sh bits, to nearest, ties away from zero.
  function automatic longint round_off(input longint v, input int sh);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return round_off(a * b, 30);
  endfunction

  function automatic void sine_cosine(input logic [AW-1:0] ang, output longint s_o,
                                      output longint c_o);
    logic [31:0] a32;
    longint unsigned u, v, x, x2, t;
    longint s, c, tmp;
    longint unsigned sdiv[5];
    longint unsigned cdiv[6];
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12, 2};
    a32 = {ang, {(32 - AW){1'b0}}};
    u = a32[29:0];
    v = (u <= (64'd1 << 29)) ? u : ONE_Q30 - u;
    x = (v * 64'hC90F_DAA2 + ONE_Q30) >> 31;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int i = 0; i < 5; i++) t = ONE_Q30 - ((x2 * t) >> 30) / sdiv[i];
    s = longint'((x * t) >> 30);
    t = ONE_Q30;
    for (int i = 0; i < 6; i++) t = ONE_Q30 - ((x2 * t) >> 30) / cdiv[i];
    c = longint'(t);
    if (u > (64'd1 << 29)) begin
      tmp = s; s = c; c = tmp;
    end
    case (a32[31:30])
      ezrm_pkg::QUAD_0: begin s_o = s;  c_o = c;  end
      ezrm_pkg::QUAD_1: begin s_o = c;  c_o = -s; end
      ezrm_pkg::QUAD_2: begin s_o = -s; c_o = -c; end
      default:          begin s_o = -c; c_o = s;  end
    endcase
  endfunction

  function automatic logic [CW-1:0] to_coef(input longint v);
    longint r;
    r = round_off(v, 30 - FB);
    if (r > (64'sd1 <<< FB)) r = 64'sd1 <<< FB;
    if (r < -(64'sd1 <<< FB)) r = -(64'sd1 <<< FB);
    return r[CW-1:0];
  endfunction

  function automatic matrix_t rotation_zxy(input logic [AW-1:0] ax, input logic [AW-1:0] ay,
                                           input logic [AW-1:0] az);
    longint sx, cx, sy, cy, sz, cz;
    matrix_t m;
    sine_cosine(ax, sx, cx);
    sine_cosine(ay, sy, cy);
    sine_cosine(az, sz, cz);
    m[0] = to_coef(q30_mul(cy, cz) + q30_mul(q30_mul(sy, sx), sz));
    m[1] = to_coef(q30_mul(sz, cx));
    m[2] = to_coef(-q30_mul(sy, cz) + q30_mul(q30_mul(cy, sx), sz));
    m[3] = to_coef(-q30_mul(cy, sz) + q30_mul(q30_mul(sy, sx), cz));
    m[4] = to_coef(q30_mul(cz, cx));
    m[5] = to_coef(q30_mul(sz, sy) + q30_mul(q30_mul(cy, sx), cz));
    m[6] = to_coef(q30_mul(sy, cx));
    m[7] = to_coef(-sx);
    m[8] = to_coef(q30_mul(cy, cx));
    return m;
  endfunction

  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Hold the payload until accepted, then queue the expected matrix.
  task automatic send_angles(input logic [AW-1:0] ax, input logic [AW-1:0] ay,
                             input logic [AW-1:0] az, input bit typed,
                             input matrix_t typed_m);
    int gap;
    gap = random_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    angle_x <= ax;
    angle_y <= ay;
    angle_z <= az;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_matrices.push_back(typed ? typed_m : rotation_zxy(ax, ay, az));
  endtask

  function automatic logic [AW-1:0] near_boundary();
    logic [AW-1:0] base;
    base = AW'($urandom_range(0, 7)) << (AW - 3);
    return base + AW'($urandom_range(0, 6)) - AW'(3);
  endfunction

  function automatic logic [AW-1:0] pick_angle();
    return ($urandom_range(0, 3) == 0) ? near_boundary() : AW'($urandom());
  endfunction

  // Directed rows: expected entries typed only for zero and a quarter or half turn about X.
  typedef struct {
    logic [AW-1:0] ax, ay, az;
    bit typed;
    matrix_t m;
  } row_t;

  row_t directed_rows[] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, {P1, 16'sd0, 16'sd0, 16'sd0, P1, 16'sd0, 16'sd0, 16'sd0, P1}},
    '{16'h4000, 16'h0000, 16'h0000, 1'b1, {16'sd0, M1, 16'sd0, P1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, P1}},
    '{16'h8000, 16'h0000, 16'h0000, 1'b1, {M1, 16'sd0, 16'sd0, 16'sd0, M1, 16'sd0, 16'sd0, 16'sd0, P1}},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{16'h0000, 16'h4000, 16'h0000, 1'b0, '0},
    '{16'h0000, 16'h0000, 16'h4000, 1'b0, '0},
    '{16'hC000, 16'h8000, 16'hC000, 1'b0, '0},
    '{16'h2000, 16'h2000, 16'h2000, 1'b0, '0},
    '{16'h1FFF, 16'h2001, 16'h6000, 1'b0, '0},
    '{16'hA000, 16'hE000, 16'h6001, 1'b0, '0},
    '{16'h0001, 16'h7FFF, 16'h8001, 1'b0, '0},
    '{16'h3FFF, 16'hBFFF, 16'h4001, 1'b0, '0},
    '{16'h5555, 16'hAAAA, 16'h1234, 1'b0, '0},
    '{16'hAAAA, 16'h5555, 16'hEDCB, 1'b0, '0}
  };

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_angles(directed_rows[i].ax, directed_rows[i].ay, directed_rows[i].az,
                  directed_rows[i].typed, directed_rows[i].m);
    for (int i = 0; i < N_RANDOM; i++)
      send_angles(pick_angle(), pick_angle(), pick_angle(), 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("euler_zxy_rotation_matrix_tb OK");
    end else begin
      $display("euler_zxy_rotation_matrix_tb NOT OK");
    end
    $finish;
  end

  // Receiver stalls; alternate between a stalling mode and a free-running one.
  int stall_left = 0;
  int mode_left = 0;
  bit stall_mode = 1'b0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2) != 0;
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_mode && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= random_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  string entry_names[9] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};

  always @(posedge clk) begin
    matrix_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
      if (pending_matrices.size() == 0) begin
        $error("unexpected output transaction");
        errors++;
      end else begin
        want = pending_matrices.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== want[k]) begin
            $error("%s: expected %0d, got %0d", entry_names[k],
                   $signed(want[k]), $signed(got[k]));
            errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("euler_zxy_rotation_matrix_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/ezrm_pkg.sv
hdl/euler_zxy_rotation_matrix.sv
tb/sv/euler_zxy_rotation_matrix_tb.sv
